// ===== src/dfrs_pkg.sv =====
// ----------------------------------------------------------------------------
// dfrs_pkg
// shared types and constants of the directional floor request set
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dfrs_pkg;

  localparam int FLOORS  = 16;
  localparam int FLOOR_W = 4;
  localparam int EXTRA_W = FLOOR_W + 1;  // valid bit over target
  localparam int ADDR_W  = 3;

  // register byte addresses
  localparam logic [ADDR_W-1:0] ADDR_DIRECTION = ADDR_W'(0);

  typedef enum logic [1:0] {
    CMD_PUSH      = 2'd0,
    CMD_POP_FRONT = 2'd1,
    CMD_POP_FLOOR = 2'd2,
    CMD_PEEK      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIND,
    ST_REPORT,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture the input word
    logic exec;    // search and update the set
    logic report;  // read extra target, encode front, register result
  } dp_cmd_t;

endpackage

// ===== src/dfrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// dfrs_ctrl
// command sequencer: capture, search/update, report, result strobe
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfrs_ctrl
  import dfrs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  output logic    done,
  output dp_cmd_t dp_cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = start && ((state == ST_IDLE) || (state == ST_DONE));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_FIND;
      end
      ST_FIND:   state_next = ST_REPORT;
      ST_REPORT: state_next = ST_DONE;
      ST_DONE: begin
        state_next = accept ? ST_FIND : ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    dp_cmd.load   = accept;
    dp_cmd.exec   = 1'b0;
    dp_cmd.report = 1'b0;
    busy          = 1'b0;
    done          = 1'b0;
    case (state)
      ST_IDLE: ;
      ST_FIND: begin
        dp_cmd.exec = 1'b1;
        busy        = 1'b1;
      end
      ST_REPORT: begin
        dp_cmd.report = 1'b1;
        busy          = 1'b1;
      end
      ST_DONE: done = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== src/dfrs_datapath.sv =====
// ----------------------------------------------------------------------------
// dfrs_datapath
// pending-floor bitmap, extra target store, priority encoders, result word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfrs_datapath
  import dfrs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            dp_cmd,
  input  logic               direction_down,
  input  logic [1:0]         cmd,
  input  logic [FLOOR_W-1:0] floor,
  input  logic               extra_valid,
  input  logic [FLOOR_W-1:0] extra_target,
  output logic               found,
  output logic [FLOOR_W-1:0] result_floor,
  output logic               result_extra_valid,
  output logic [FLOOR_W-1:0] result_extra_target,
  output logic               duplicate,
  output logic               front_valid,
  output logic [FLOOR_W-1:0] front_floor
);

  // lowest set bit, valid flag on top
  function automatic logic [FLOOR_W:0] enc_low(input logic [FLOORS-1:0] mask);
    logic [FLOOR_W:0] r;
    r = '0;
    for (int i = FLOORS - 1; i >= 0; i--) begin
      if (mask[i]) r = {1'b1, FLOOR_W'(i)};
    end
    return r;
  endfunction

  // highest set bit, valid flag on top
  function automatic logic [FLOOR_W:0] enc_high(input logic [FLOORS-1:0] mask);
    logic [FLOOR_W:0] r;
    r = '0;
    for (int i = 0; i < FLOORS; i++) begin
      if (mask[i]) r = {1'b1, FLOOR_W'(i)};
    end
    return r;
  endfunction

  cmd_t               cmd_r;
  logic [FLOOR_W-1:0] floor_r;
  logic               xv_r;
  logic [FLOOR_W-1:0] xt_r;

  logic [FLOORS-1:0]  pending;
  logic [FLOORS-1:0]  pending_next;
  logic [EXTRA_W-1:0] extra_mem [FLOORS];

  logic               hit;
  logic               hit_next;
  logic [FLOOR_W-1:0] hit_idx;
  logic [FLOOR_W-1:0] hit_idx_next;
  logic               dup;
  logic               dup_next;
  logic               extra_wr;

  logic [FLOORS-1:0]  peek_mask;
  logic [FLOOR_W:0]   front_enc;
  logic [FLOOR_W:0]   peek_enc;
  logic [EXTRA_W-1:0] rx;

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_r   <= cmd_t'(cmd);
      floor_r <= floor;
      xv_r    <= extra_valid;
      xt_r    <= extra_target;
    end
  end

  // search window for peek, in travel direction from the start floor
  always_comb begin
    for (int i = 0; i < FLOORS; i++) begin
      if (direction_down) begin
        peek_mask[i] = pending[i] && (FLOOR_W'(i) <= floor_r);
      end else begin
        peek_mask[i] = pending[i] && (FLOOR_W'(i) >= floor_r);
      end
    end
  end

  assign front_enc = direction_down ? enc_high(pending) : enc_low(pending);
  assign peek_enc  = direction_down ? enc_high(peek_mask) : enc_low(peek_mask);

  always_comb begin
    pending_next = pending;
    hit_next     = 1'b0;
    hit_idx_next = floor_r;
    dup_next     = 1'b0;
    extra_wr     = 1'b0;
    case (cmd_r)
      CMD_PUSH: begin
        if (pending[floor_r]) begin
          dup_next = 1'b1;
        end else begin
          pending_next[floor_r] = 1'b1;
          hit_next              = 1'b1;
          extra_wr              = 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        hit_next     = front_enc[FLOOR_W];
        hit_idx_next = front_enc[FLOOR_W-1:0];
        if (front_enc[FLOOR_W]) pending_next[front_enc[FLOOR_W-1:0]] = 1'b0;
      end
      CMD_POP_FLOOR: begin
        if (pending[floor_r]) begin
          hit_next              = 1'b1;
          pending_next[floor_r] = 1'b0;
        end
      end
      CMD_PEEK: begin
        hit_next     = peek_enc[FLOOR_W];
        hit_idx_next = peek_enc[FLOOR_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (dp_cmd.exec) begin
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.exec) begin
      hit     <= hit_next;
      hit_idx <= hit_idx_next;
      dup     <= dup_next;
    end
  end

  // extra target store, written only when a floor becomes pending
  always_ff @(posedge clk) begin
    if (dp_cmd.exec && extra_wr) begin
      extra_mem[floor_r] <= xv_r ? {1'b1, xt_r} : '0;
    end
  end

  assign rx = extra_mem[hit_idx];

  always_ff @(posedge clk) begin
    if (dp_cmd.report) begin
      found               <= hit;
      result_floor        <= hit ? hit_idx : '0;
      result_extra_valid  <= hit && rx[FLOOR_W];
      result_extra_target <= (hit && rx[FLOOR_W]) ? rx[FLOOR_W-1:0] : '0;
      duplicate           <= dup;
      front_valid         <= front_enc[FLOOR_W];
      front_floor         <= front_enc[FLOOR_W] ? front_enc[FLOOR_W-1:0] : '0;
    end
  end

endmodule

// ===== src/directional_floor_request_set.sv =====
// ----------------------------------------------------------------------------
// directional_floor_request_set
// set of pending target floors ordered by travel direction
// ----------------------------------------------------------------------------
// usage
//   command word: start with cmd, floor, extra_valid, extra_target; taken at
//   a rising edge with start high and busy low
//   commands: push, pop front, pop given floor, peek first floor at or
//   beyond a given floor in travel direction
//   result word: found, result_floor, result_extra_valid,
//   result_extra_target, duplicate, front_valid, front_floor, shown for
//   exactly one cycle while done is high; the receiver cannot stall it
//   sequence: the accepting edge captures the word, then the find state
//   searches and updates the set and the report state registers the result;
//   a command is taken only while busy is low, so at most one is in flight;
//   a new command may be taken in the cycle its predecessor's result is shown
//   config: apb register 0 (byte address 0) bit 0 is direction_down,
//   0 up / ascending, 1 down / descending; write only while idle
//   reset: set empty, direction up, no result pending; extra targets are
//   left undefined, each is written when its floor becomes pending
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module directional_floor_request_set
  import dfrs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // command word
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd,
  input  logic [FLOOR_W-1:0] floor,
  input  logic               extra_valid,
  input  logic [FLOOR_W-1:0] extra_target,
  // result word
  output logic               done,
  output logic               found,
  output logic [FLOOR_W-1:0] result_floor,
  output logic               result_extra_valid,
  output logic [FLOOR_W-1:0] result_extra_target,
  output logic               duplicate,
  output logic               front_valid,
  output logic [FLOOR_W-1:0] front_floor,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  dp_cmd_t dp_cmd;
  logic    direction_down;
  logic    cfg_sel;
  logic    cfg_wr;

  // apb: no wait states, register 0 holds the direction bit
  // decode on the word address, byte lanes ignored
  assign pready  = 1'b1;
  assign cfg_sel = (paddr[ADDR_W-1:2] == ADDR_DIRECTION[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction_down <= 1'b0;
    end else if (cfg_wr) begin
      direction_down <= pwdata[0];
    end
  end

  // unmapped addresses read as zero
  assign prdata = cfg_sel ? {31'b0, direction_down} : 32'b0;

  // sequencer: capture, search and update, report
  dfrs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .dp_cmd (dp_cmd)
  );

  // bitmap, extra target store and encoders
  dfrs_datapath u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .dp_cmd              (dp_cmd),
    .direction_down      (direction_down),
    .cmd                 (cmd),
    .floor               (floor),
    .extra_valid         (extra_valid),
    .extra_target        (extra_target),
    .found               (found),
    .result_floor        (result_floor),
    .result_extra_valid  (result_extra_valid),
    .result_extra_target (result_extra_target),
    .duplicate           (duplicate),
    .front_valid         (front_valid),
    .front_floor         (front_floor)
  );

endmodule

// ===== verif/tb_directional_floor_request_set.sv =====
// ----------------------------------------------------------------------------
// tb_directional_floor_request_set
// self-checking bench for the direction-ordered floor request set
// ----------------------------------------------------------------------------
// a queue of command words feeds a clocked driver on the start/busy
// handshake; each accepted word is run through a local model of the set
// (pending bitmap, per-floor extra target, travel direction) and the
// predicted result word is queued; a clocked monitor checks every done
// strobe against the oldest prediction, field by field. the direction
// register is written over apb between phases, only with the block idle,
// and read back. a directed opening covers empty set, duplicate push,
// missing extra target, pop of the front and both directions; random
// phases with varying push density follow
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_directional_floor_request_set;
  import dfrs_pkg::*;

  localparam int STALL_LIMIT = 2000;  // cycles without any accepted word or result
  localparam int SETTLE      = 6;     // margin after the last result word

  // one command word as the bench sees it
  typedef struct packed {
    cmd_t               op;
    logic [FLOOR_W-1:0] floor;
    logic               extra_valid;
    logic [FLOOR_W-1:0] extra_target;
  } floor_cmd_t;

  // one result word
  typedef struct packed {
    logic               found;
    logic [FLOOR_W-1:0] floor;
    logic               extra_valid;
    logic [FLOOR_W-1:0] extra_target;
    logic               duplicate;
    logic               front_valid;
    logic [FLOOR_W-1:0] front_floor;
  } floor_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         cmd = CMD_PUSH;
  logic [FLOOR_W-1:0] floor = '0;
  logic               extra_valid = 1'b0;
  logic [FLOOR_W-1:0] extra_target = '0;
  logic               done;
  logic               found;
  logic [FLOOR_W-1:0] result_floor;
  logic               result_extra_valid;
  logic [FLOOR_W-1:0] result_extra_target;
  logic               duplicate;
  logic               front_valid;
  logic [FLOOR_W-1:0] front_floor;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  directional_floor_request_set u_top (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .busy                (busy),
    .cmd                 (cmd),
    .floor               (floor),
    .extra_valid         (extra_valid),
    .extra_target        (extra_target),
    .done                (done),
    .found               (found),
    .result_floor        (result_floor),
    .result_extra_valid  (result_extra_valid),
    .result_extra_target (result_extra_target),
    .duplicate           (duplicate),
    .front_valid         (front_valid),
    .front_floor         (front_floor),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // local model of the set
  // ---------------------------------------------------------------------------
  logic [FLOORS-1:0]  floor_pending = '0;
  logic [EXTRA_W-1:0] extra_by_floor [FLOORS];  // valid bit over target
  logic               travel_down = 1'b0;

  floor_cmd_t    floor_cmds_to_send [$];  // words not yet offered
  floor_result_t scan_results_due [$];    // predictions awaiting done
  floor_cmd_t    word_on_port;            // word currently offered
  floor_result_t next_due;
  int            err_count = 0;
  int            idle_cycles = 0;
  bit            steady_feed = 1'b0;      // suppress driver gaps

  // first pending floor at or beyond from, walking in travel direction
  task automatic scan_pending(input logic [FLOOR_W-1:0] from, output logic hit,
                              output logic [FLOOR_W-1:0] at);
    int i;
    hit = 1'b0;
    at  = '0;
    if (travel_down) begin
      for (i = from; i >= 0; i--) begin
        if (floor_pending[i] && !hit) begin
          hit = 1'b1;
          at  = FLOOR_W'(i);
        end
      end
    end else begin
      for (i = from; i < FLOORS; i++) begin
        if (floor_pending[i] && !hit) begin
          hit = 1'b1;
          at  = FLOOR_W'(i);
        end
      end
    end
  endtask

  // apply one command to the model and work out its result word
  task automatic step_floor_set(input floor_cmd_t c, output floor_result_t r);
    logic               hit;
    logic [FLOOR_W-1:0] hit_floor;
    logic [EXTRA_W-1:0] ext;
    logic [FLOOR_W-1:0] head;
    r         = '0;
    hit       = 1'b0;
    hit_floor = '0;
    head      = travel_down ? FLOOR_W'(FLOORS - 1) : '0;
    case (c.op)
      CMD_PUSH: begin
        // duplicate keeps the old entry, new extra target dropped
        if (floor_pending[c.floor]) begin
          r.duplicate = 1'b1;
        end else begin
          floor_pending[c.floor]  = 1'b1;
          extra_by_floor[c.floor] = c.extra_valid ? {1'b1, c.extra_target} : '0;
          hit       = 1'b1;
          hit_floor = c.floor;
        end
      end
      CMD_POP_FRONT: begin
        scan_pending(head, hit, hit_floor);
        if (hit) floor_pending[hit_floor] = 1'b0;
      end
      CMD_POP_FLOOR: begin
        if (floor_pending[c.floor]) begin
          hit       = 1'b1;
          hit_floor = c.floor;
          floor_pending[c.floor] = 1'b0;
        end
      end
      default: begin
        scan_pending(c.floor, hit, hit_floor);
      end
    endcase
    if (hit) begin
      ext            = extra_by_floor[hit_floor];
      r.found        = 1'b1;
      r.floor        = hit_floor;
      r.extra_valid  = ext[FLOOR_W];
      r.extra_target = ext[FLOOR_W] ? ext[FLOOR_W-1:0] : '0;
    end
    // front after the command, in the current direction
    scan_pending(head, r.front_valid, r.front_floor);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers queued words, predicts each one as it is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        step_floor_set(word_on_port, next_due);
        scan_results_due.push_back(next_due);
      end
      // a word still waiting on busy stays on the port untouched
      if (!start || !busy) begin
        if (floor_cmds_to_send.size() != 0 &&
            (steady_feed || $urandom_range(99) >= 35)) begin
          word_on_port = floor_cmds_to_send.pop_front();
          start        <= 1'b1;
          cmd          <= word_on_port.op;
          floor        <= word_on_port.floor;
          extra_valid  <= word_on_port.extra_valid;
          extra_target <= word_on_port.extra_target;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: each done strobe against the oldest prediction
  // ---------------------------------------------------------------------------
  floor_result_t want;

  always @(posedge clk) begin
    if (!rst && done) begin
      if (scan_results_due.size() == 0) begin
        report_mismatch("result word with none outstanding", 1, 0);
      end else begin
        want = scan_results_due.pop_front();
        if (found !== want.found)
          report_mismatch("found", found, want.found);
        if (result_floor !== want.floor)
          report_mismatch("result_floor", result_floor, want.floor);
        if (result_extra_valid !== want.extra_valid)
          report_mismatch("result_extra_valid", result_extra_valid, want.extra_valid);
        if (result_extra_target !== want.extra_target)
          report_mismatch("result_extra_target", result_extra_target, want.extra_target);
        if (duplicate !== want.duplicate)
          report_mismatch("duplicate", duplicate, want.duplicate);
        if (front_valid !== want.front_valid)
          report_mismatch("front_valid", front_valid, want.front_valid);
        if (front_floor !== want.front_floor)
          report_mismatch("front_floor", front_floor, want.front_floor);
      end
    end
  end

  // watchdog: too long with no word taken and no result shown
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_directional_floor_request_set failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_cmd(input cmd_t op, input int fl, input bit xv, input int xt);
    floor_cmd_t c;
    c.op           = op;
    c.floor        = FLOOR_W'(fl);
    c.extra_valid  = xv;
    c.extra_target = FLOOR_W'(xt);
    floor_cmds_to_send.push_back(c);
  endtask

  // push density steers the set between mostly full and mostly empty
  function automatic floor_cmd_t random_floor_cmd(input int push_pct);
    floor_cmd_t c;
    if ($urandom_range(99) < push_pct) begin
      c.op = CMD_PUSH;
    end else begin
      case ($urandom_range(2))
        0:       c.op = CMD_POP_FRONT;
        1:       c.op = CMD_POP_FLOOR;
        default: c.op = CMD_PEEK;
      endcase
    end
    c.floor        = FLOOR_W'($urandom_range(FLOORS - 1));
    c.extra_valid  = 1'($urandom_range(1));
    c.extra_target = FLOOR_W'($urandom_range(FLOORS - 1));
    return c;
  endfunction

  // wait until every word is taken and answered, then let the block settle
  task automatic wait_set_idle();
    while (floor_cmds_to_send.size() != 0 || start || scan_results_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // apb write of the direction register, then read it back
  task automatic write_direction(input bit down);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_DIRECTION;
    pwdata  <= {31'b0, down};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // register taken at this edge
    travel_down = down;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {31'b0, travel_down})
      report_mismatch("direction readback", prdata, travel_down);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int push_pct [6];
    bit phase_dir [6];
    int p;
    int n;
    push_pct  = '{70, 30, 50, 80, 20, 55};
    phase_dir = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed, going up
    write_direction(1'b0);
    queue_cmd(CMD_PEEK,      0,  1'b0, 0);   // empty set
    queue_cmd(CMD_POP_FRONT, 0,  1'b0, 0);   // pop front on empty
    queue_cmd(CMD_PUSH,      0,  1'b1, 15);
    queue_cmd(CMD_PUSH,      15, 1'b0, 10);  // no extra, target dropped
    queue_cmd(CMD_PUSH,      0,  1'b1, 3);   // duplicate, old entry kept
    queue_cmd(CMD_PUSH,      7,  1'b1, 0);
    queue_cmd(CMD_PEEK,      8,  1'b0, 0);   // finds 15 without extra
    queue_cmd(CMD_PEEK,      0,  1'b0, 0);
    queue_cmd(CMD_POP_FLOOR, 9,  1'b0, 0);   // not pending
    queue_cmd(CMD_POP_FLOOR, 0,  1'b0, 0);   // front removed, front moves on
    queue_cmd(CMD_POP_FRONT, 0,  1'b0, 0);
    queue_cmd(CMD_PEEK,      15, 1'b0, 0);
    wait_set_idle();

    // directed, going down with floor 15 still pending
    write_direction(1'b1);
    queue_cmd(CMD_PUSH,      3,  1'b1, 9);
    queue_cmd(CMD_PUSH,      10, 1'b1, 5);
    queue_cmd(CMD_PEEK,      15, 1'b0, 0);
    queue_cmd(CMD_PEEK,      9,  1'b0, 0);
    queue_cmd(CMD_PEEK,      2,  1'b0, 0);   // nothing below
    queue_cmd(CMD_POP_FRONT, 0,  1'b0, 0);
    queue_cmd(CMD_POP_FLOOR, 10, 1'b0, 0);   // pop of the front entry
    queue_cmd(CMD_POP_FRONT, 0,  1'b0, 0);
    queue_cmd(CMD_POP_FRONT, 0,  1'b0, 0);   // now empty
    queue_cmd(CMD_PUSH,      15, 1'b1, 15);
    queue_cmd(CMD_PUSH,      15, 1'b0, 0);
    wait_set_idle();

    // random phases; the set carries over so direction flips see live entries
    for (p = 0; p < 6; p++) begin
      write_direction(phase_dir[p]);
      steady_feed = (p == 3);
      for (n = 0; n < 150; n++)
        floor_cmds_to_send.push_back(random_floor_cmd(push_pct[p]));
      wait_set_idle();
    end

    if (err_count == 0) begin
      $display("tb_directional_floor_request_set passed");
    end else begin
      $display("tb_directional_floor_request_set failed");
    end
    $finish;
  end

endmodule
